// ===== design/bfmr_pkg.sv =====
package bfmr_pkg;

  localparam logic [1:0] ACT_TABLE  = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;
  localparam logic [1:0] CFG_TABLE  = 2'd3;

  localparam logic [7:0] BYTE_GLYPH_SEP = 8'hFF;
  localparam logic [7:0] CONT_MASK      = 8'h3F;
  localparam logic [7:0] LEAD2_MASK     = 8'b11100000;
  localparam logic [7:0] LEAD2_CODE     = 8'b11000000;
  localparam logic [7:0] LEAD3_MASK     = 8'b11110000;
  localparam logic [7:0] LEAD3_CODE     = 8'b11100000;
  localparam logic [7:0] LEAD4_MASK     = 8'b11111000;
  localparam logic [7:0] LEAD4_CODE     = 8'b11110000;
  localparam logic [7:0] CONT_TEST_MASK = 8'b11000000;
  localparam logic [7:0] CONT_CODE      = 8'b10000000;
  localparam logic [20:0] CP_MAP_LIMIT  = 21'd65535;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic        simple;   // one result with the given status
    logic [1:0]  status;
    logic        map_wr;
    logic [15:0] map_addr;
    logic        glyph_wr;
    logic [8:0]  glyph;
    logic [4:0]  row;
    logic [7:0]  data;
    logic        lookup;   // render through the map
    logic [20:0] codepoint;
    logic [31:0] fg;
    logic [31:0] bg;
  } cmd_t;

endpackage

// ===== design/bfmr_front.sv =====
module bfmr_front #(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_action,
  input  logic [7:0]    in_data_byte,
  input  logic [8:0]    in_glyph_index,
  input  logic [4:0]    in_row_number,
  input  logic [20:0]   in_codepoint,
  input  logic [31:0]   in_fg_color,
  input  logic [31:0]   in_bg_color,
  input  logic          table_present,
  input  logic          q_full,
  output logic          q_push,
  output bfmr_pkg::cmd_t q_cmd
);
  import bfmr_pkg::*;

  logic [8:0]  gcnt_r, gcnt_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] part_r, part_nxt;
  logic [20:0] cp_full;
  logic        accept;
  cmd_t        c;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cp_full  = {part_r[14:0], in_data_byte[5:0] & CONT_MASK[5:0]};

  always_comb begin
    gcnt_nxt = gcnt_r;
    pend_nxt = pend_r;
    part_nxt = part_r;
    c = '0;
    c.simple    = 1'b1;
    c.status    = ST_OK;
    c.glyph     = in_glyph_index;
    c.row       = in_row_number;
    c.data      = in_data_byte;
    c.codepoint = in_codepoint;
    c.fg        = in_fg_color;
    c.bg        = in_bg_color;
    case (in_action)
      ACT_TABLE: begin
        if (pend_r != 2'd0) begin
          if ((in_data_byte & CONT_TEST_MASK) != CONT_CODE) begin
            pend_nxt = 2'd0;
            part_nxt = '0;
            c.status = ST_MALFORMED;
          end else begin
            part_nxt = cp_full;
            pend_nxt = pend_r - 2'd1;
            if (pend_r == 2'd1) begin
              if (cp_full >= CP_MAP_LIMIT || cp_full >= 21'(MAP_ENTRIES))
                c.status = ST_TOO_LARGE;
              else begin
                c.map_wr   = 1'b1;
                c.map_addr = cp_full[15:0];
              end
            end
          end
        end else if (in_data_byte == BYTE_GLYPH_SEP) begin
          gcnt_nxt = gcnt_r + 9'd1;
        end else if (!in_data_byte[7]) begin
          c.map_wr   = 1'b1;
          c.map_addr = {8'd0, in_data_byte};
        end else if ((in_data_byte & LEAD2_MASK) == LEAD2_CODE) begin
          pend_nxt = 2'd1;
          part_nxt = {16'd0, in_data_byte[4:0]};
        end else if ((in_data_byte & LEAD3_MASK) == LEAD3_CODE) begin
          pend_nxt = 2'd2;
          part_nxt = {17'd0, in_data_byte[3:0]};
        end else if ((in_data_byte & LEAD4_MASK) == LEAD4_CODE) begin
          pend_nxt = 2'd3;
          part_nxt = {18'd0, in_data_byte[2:0]};
        end else begin
          c.status = ST_MALFORMED;
        end
      end
      ACT_WRITE: c.glyph_wr = 1'b1;
      ACT_RENDER: begin
        c.simple = 1'b0;
        if (table_present) begin
          if (in_codepoint >= 21'(MAP_ENTRIES)) begin
            c.simple = 1'b1;
            c.status = ST_TOO_LARGE;
          end else c.lookup = 1'b1;
        end
      end
      default: c.status = ST_OK;
    endcase
    // The map entry gets the counter value current at decode time.
    c.glyph = (c.map_wr) ? gcnt_r : c.glyph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= '0;
      pend_r <= '0;
      part_r <= '0;
    end else if (accept) begin
      gcnt_r <= gcnt_nxt;
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end

  assign q_push = accept;
  assign q_cmd  = c;
endmodule

// ===== design/bfmr_queue.sv =====
module bfmr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfmr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bfmr_pkg::cmd_t head
);
  import bfmr_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/bfmr_back.sv =====
module bfmr_back #(
  parameter int MAP_ENTRIES = 65536,
  parameter int MAX_GLYPHS  = 512,
  parameter int MAX_ROWS    = 32,
  parameter int MAX_WIDTH   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [3:0]     glyph_width,
  input  logic [5:0]     glyph_height,
  input  logic [9:0]     glyph_count,
  input  logic           q_valid,
  input  bfmr_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [4:0]     out_out_row,
  output logic [31:0]    out_pixel_0,
  output logic [31:0]    out_pixel_1,
  output logic [31:0]    out_pixel_2,
  output logic [31:0]    out_pixel_3,
  output logic [31:0]    out_pixel_4,
  output logic [31:0]    out_pixel_5,
  output logic [31:0]    out_pixel_6,
  output logic [31:0]    out_pixel_7,
  output logic           out_last_row
);
  import bfmr_pkg::*;

  localparam int MAW = $clog2(MAP_ENTRIES);
  localparam int GW  = $clog2(MAX_GLYPHS);
  localparam int RW  = $clog2(MAX_ROWS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [8:0]  map_mem [MAP_ENTRIES];
  logic [7:0]  gly_mem [MAX_GLYPHS*MAX_ROWS];

  logic [2:0]    st_r, st_nxt;
  logic [MAW:0]  clr_r;
  logic [8:0]    map_q_r, glyph_r;
  logic [7:0]    bits_r;
  logic [4:0]    y_r;
  logic [31:0]   fg_r, bg_r;
  logic [3:0]    w_c;
  logic [5:0]    h_c;
  logic [9:0]    lim_c;
  logic          busy_out;
  logic          out_valid_r;
  logic [1:0]    ost_r;
  logic [4:0]    orow_r;
  logic [31:0]   px_r [8];
  logic          olast_r;
  logic          can_load;
  logic          hit_c;
  logic          last_c;

  always_comb begin
    w_c = glyph_width;
    if (w_c == 4'd0) w_c = 4'd1;
    if (w_c > 4'(MAX_WIDTH)) w_c = 4'(MAX_WIDTH);
    h_c = glyph_height;
    if (h_c == 6'd0) h_c = 6'd1;
    if (h_c > 6'(MAX_ROWS)) h_c = 6'(MAX_ROWS);
    lim_c = glyph_count;
    if (lim_c > 10'(MAX_GLYPHS)) lim_c = 10'(MAX_GLYPHS);
  end

  assign clearing = st_r == S_CLEAR;
  assign busy_out = out_valid_r && out_stall;
  assign can_load = !busy_out;
  // Without the map the whole code point is the glyph, so its upper bits count too.
  assign hit_c    = !(!q_head.lookup && q_head.codepoint[20:9] != 12'd0) &&
                    ({1'b0, glyph_r} < lim_c);
  assign last_c   = {1'b0, y_r} == h_c - 6'd1;

  // Map memory: the clearing sweep and table writes share the write port.
  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR) map_mem[clr_r[MAW-1:0]] <= '0;
    else if (st_r == S_IDLE && q_valid && q_head.map_wr)
      map_mem[q_head.map_addr[MAW-1:0]] <= q_head.glyph;
    map_q_r <= map_mem[q_head.codepoint[MAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_head.glyph_wr &&
        {1'b0, q_head.glyph} < 10'(MAX_GLYPHS) && {1'b0, q_head.row} < 6'(MAX_ROWS))
      gly_mem[{q_head.glyph[GW-1:0], q_head.row[RW-1:0]}] <= q_head.data;
    bits_r <= gly_mem[{glyph_r[GW-1:0], y_r[RW-1:0]}];
  end

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      S_CLEAR: if (clr_r == (MAW+1)'(MAP_ENTRIES - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid && can_load) begin
          if (q_head.simple || q_head.glyph_wr) q_pop = 1'b1;
          else if (q_head.lookup) st_nxt = S_MAP;
          else st_nxt = S_CHECK;
        end
      end
      S_MAP:   st_nxt = S_CHECK;
      S_CHECK: st_nxt = hit_c ? S_READ : S_IDLE;
      S_READ:  st_nxt = S_EMIT;
      S_EMIT: if (can_load) st_nxt = last_c ? S_IDLE : S_READ;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_CHECK && !hit_c) q_pop = 1'b1;
    if (st_r == S_EMIT && can_load && last_c) q_pop = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      y_r         <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (st_r == S_IDLE && q_valid && can_load && (q_head.simple || q_head.glyph_wr))
        out_valid_r <= 1'b1;
      if (st_r == S_CHECK && !hit_c) out_valid_r <= 1'b1;
      if (st_r == S_EMIT && can_load) out_valid_r <= 1'b1;
      if (st_r == S_CHECK) y_r <= '0;
      if (st_r == S_EMIT && can_load) y_r <= y_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE) begin
      fg_r    <= q_head.fg;
      bg_r    <= q_head.bg;
      glyph_r <= q_head.codepoint[8:0];
    end
    if (st_r == S_MAP) glyph_r <= map_q_r;
    if (st_r == S_IDLE && q_valid && can_load && (q_head.simple || q_head.glyph_wr)) begin
      ost_r   <= q_head.glyph_wr &&
                 !({1'b0, q_head.glyph} < 10'(MAX_GLYPHS) &&
                   {1'b0, q_head.row} < 6'(MAX_ROWS)) ? ST_RANGE : q_head.status;
      orow_r  <= '0;
      olast_r <= 1'b1;
      for (int i = 0; i < 8; i++) px_r[i] <= '0;
    end
    if (st_r == S_CHECK && !hit_c) begin
      ost_r   <= ST_RANGE;
      orow_r  <= '0;
      olast_r <= 1'b1;
      for (int i = 0; i < 8; i++) px_r[i] <= '0;
    end
    if (st_r == S_EMIT && can_load) begin
      ost_r   <= ST_OK;
      orow_r  <= y_r;
      olast_r <= last_c;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < w_c) px_r[i] <= bits_r[3'(w_c - 4'd1 - 4'(i))] ? fg_r : bg_r;
        else px_r[i] <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = ost_r;
  assign out_out_row  = orow_r;
  assign out_pixel_0  = px_r[0];
  assign out_pixel_1  = px_r[1];
  assign out_pixel_2  = px_r[2];
  assign out_pixel_3  = px_r[3];
  assign out_pixel_4  = px_r[4];
  assign out_pixel_5  = px_r[5];
  assign out_pixel_6  = px_r[6];
  assign out_pixel_7  = px_r[7];
  assign out_last_row = olast_r;
endmodule

// ===== design/bitmap_font_map_and_raster.sv =====
// Bitmap font engine: builds a code-point-to-glyph map from a streamed UTF-8
// unicode table, stores glyph rows and renders glyphs row by row.
// Input channel (in_valid / in_stall) carries one word per action: table
// byte, glyph row write or render request. Each table byte and row write
// gives one result word; a render gives glyph_height rows, last_row on the
// final one, or a single status word on a lookup error.
// A front end decodes UTF-8 and keeps the glyph counter; a two-entry queue
// feeds a back end that owns the map and glyph memories.
// Table bytes and row writes are taken by the back end in its idle state, which
// registers their result word. A render passes through a map state when it
// looks up the map, then a check state; each emitted row has a read state for
// the registered glyph memory read and then an emit state.
// After reset the back end sweeps the map clear, one entry per cycle; input
// words queue but are not processed until then.
// When out_stall is high the result word holds and the back end waits; the
// queue fills and in_stall rises. Configuration writes are taken anytime.
module bitmap_font_map_and_raster #(
  parameter int MAP_ENTRIES = 65536,
  parameter int MAX_GLYPHS  = 512,
  parameter int MAX_ROWS    = 32,
  parameter int MAX_WIDTH   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_glyph_index,
  input  logic [4:0]  in_row_number,
  input  logic [20:0] in_codepoint,
  input  logic [31:0] in_fg_color,
  input  logic [31:0] in_bg_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_out_row,
  output logic [31:0] out_pixel_0,
  output logic [31:0] out_pixel_1,
  output logic [31:0] out_pixel_2,
  output logic [31:0] out_pixel_3,
  output logic [31:0] out_pixel_4,
  output logic [31:0] out_pixel_5,
  output logic [31:0] out_pixel_6,
  output logic [31:0] out_pixel_7,
  output logic        out_last_row
);
  import bfmr_pkg::*;

  logic [3:0] width_r;
  logic [5:0] height_r;
  logic [9:0] count_r;
  logic       table_r;
  logic       q_full, q_push, q_pop, q_ne, clearing;
  cmd_t       push_cmd, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 4'd8;
      height_r <= 6'd16;
      count_r  <= 10'd256;
      table_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[3:0];
        CFG_HEIGHT: height_r <= cfg_data[5:0];
        CFG_COUNT:  count_r  <= cfg_data;
        CFG_TABLE:  table_r  <= cfg_data[0];
        default:    table_r  <= table_r;
      endcase
    end
  end

  bfmr_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_data_byte,
    .in_glyph_index, .in_row_number, .in_codepoint, .in_fg_color, .in_bg_color,
    .table_present(table_r), .q_full, .q_push, .q_cmd(push_cmd)
  );

  bfmr_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_cmd, .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head
  );

  bfmr_back #(
    .MAP_ENTRIES(MAP_ENTRIES), .MAX_GLYPHS(MAX_GLYPHS),
    .MAX_ROWS(MAX_ROWS), .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk, .rst_n, .glyph_width(width_r), .glyph_height(height_r),
    .glyph_count(count_r), .q_valid(q_ne), .q_head(head), .q_pop, .clearing,
    .out_valid, .out_stall, .out_status, .out_out_row, .out_pixel_0, .out_pixel_1,
    .out_pixel_2, .out_pixel_3, .out_pixel_4, .out_pixel_5, .out_pixel_6,
    .out_pixel_7, .out_last_row
  );
endmodule

// ===== design/bfmr_checker.sv =====
module bfmr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [4:0] out_out_row,
  input logic       out_last_row,
  input logic [31:0] out_pixel_0
);
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_out_row)) else $error("row changed under stall");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'd0 |-> out_last_row) else $error("error word not last");
  a_err_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'd0 |-> out_out_row == 5'd0 && out_pixel_0 == 32'd0)
    else $error("error word carries pixels");
endmodule

bind bitmap_font_map_and_raster bfmr_checker u_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_out_row,
  .out_last_row, .out_pixel_0
);

// ===== tb/font_raster_checker.sv =====
`timescale 1ns / 100ps

module font_raster_checker
  import bfmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_glyph_index,
  input  logic [4:0]  in_row_number,
  input  logic [20:0] in_codepoint,
  input  logic [31:0] in_fg_color,
  input  logic [31:0] in_bg_color,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_out_row,
  input  logic [31:0] out_pixel_0,
  input  logic [31:0] out_pixel_1,
  input  logic [31:0] out_pixel_2,
  input  logic [31:0] out_pixel_3,
  input  logic [31:0] out_pixel_4,
  input  logic [31:0] out_pixel_5,
  input  logic [31:0] out_pixel_6,
  input  logic [31:0] out_pixel_7,
  input  logic        out_last_row,
  output int          mismatches,
  output int          rows_due,
  output int          words_seen
);

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       row;
    logic [7:0][31:0] px;
    logic             last;
  } row_word_t;

  row_word_t  expected_rows[$];
  logic [8:0] cp_map [65536];
  logic [7:0] row_mem [16384];
  logic [8:0] glyph_ctr;
  logic [1:0] cont_left;
  logic [20:0] cp_acc;
  logic [3:0] cfg_w;
  logic [5:0] cfg_h;
  logic [9:0] cfg_n;
  logic       cfg_tbl;

  initial begin
    for (int i = 0; i < 65536; i++) cp_map[i] = '0;
    for (int i = 0; i < 16384; i++) row_mem[i] = '0;
    glyph_ctr = '0;
    cont_left = '0;
    cp_acc = '0;
    cfg_w = 4'd8;
    cfg_h = 6'd16;
    cfg_n = 10'd256;
    cfg_tbl = 1'b0;
    mismatches = 0;
    words_seen = 0;
  end

  // Used by the stimulus to avoid rendering glyph rows that were never written.
  function automatic logic [8:0] glyph_of(input logic [20:0] cp);
    return cp_map[cp[15:0]];
  endfunction

  function automatic logic [1:0] map_cp(input logic [20:0] cp);
    if (cp >= CP_MAP_LIMIT) return ST_TOO_LARGE;
    cp_map[cp[15:0]] = glyph_ctr;
    return ST_OK;
  endfunction

  function automatic logic [1:0] decode_byte(input logic [7:0] b);
    if (cont_left != 0) begin
      if ((b & CONT_TEST_MASK) != CONT_CODE) begin
        cont_left = '0;
        cp_acc = '0;
        return ST_MALFORMED;
      end
      cp_acc = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) return map_cp(cp_acc);
      return ST_OK;
    end
    if (b == BYTE_GLYPH_SEP) begin
      glyph_ctr = glyph_ctr + 9'd1;
      return ST_OK;
    end
    if (!b[7]) return map_cp({13'd0, b});
    if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      cont_left = 2'd1;
      cp_acc = {16'd0, b[4:0]};
      return ST_OK;
    end
    if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      cont_left = 2'd2;
      cp_acc = {17'd0, b[3:0]};
      return ST_OK;
    end
    if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      cont_left = 2'd3;
      cp_acc = {18'd0, b[2:0]};
      return ST_OK;
    end
    return ST_MALFORMED;
  endfunction

  task automatic predict_word();
    row_word_t r;
    int w, h, lim;
    logic [20:0] g;
    logic [7:0] bits;
    r = '0;
    r.last = 1'b1;
    case (in_action)
      ACT_TABLE: begin
        r.status = decode_byte(in_data_byte);
        expected_rows.push_back(r);
      end
      ACT_WRITE: begin
        row_mem[{in_glyph_index, in_row_number}] = in_data_byte;
        expected_rows.push_back(r);
      end
      ACT_RENDER: begin
        w = (cfg_w == 0) ? 1 : (cfg_w > 8) ? 8 : cfg_w;
        h = (cfg_h == 0) ? 1 : (cfg_h > 32) ? 32 : cfg_h;
        lim = (cfg_n > 512) ? 512 : cfg_n;
        if (cfg_tbl && in_codepoint >= 21'd65536) begin
          r.status = ST_TOO_LARGE;
          expected_rows.push_back(r);
        end else begin
          g = cfg_tbl ? {12'd0, cp_map[in_codepoint[15:0]]} : in_codepoint;
          if (g >= lim) begin
            r.status = ST_RANGE;
            expected_rows.push_back(r);
          end else begin
            for (int y = 0; y < h; y++) begin
              bits = row_mem[{g[8:0], y[4:0]}];
              r = '0;
              r.row = y[4:0];
              for (int x = 0; x < 8; x++)
                if (x < w) r.px[x] = bits[w - 1 - x] ? in_fg_color : in_bg_color;
              r.last = (y == h - 1);
              expected_rows.push_back(r);
            end
          end
        end
      end
      default: expected_rows.push_back(r);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    row_word_t e;
    logic [7:0][31:0] got_px;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_rows.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          e = expected_rows.pop_front();
          got_px = {out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
                    out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0};
          check_field("status", e.status, out_status);
          check_field("out_row", e.row, out_out_row);
          for (int x = 0; x < 8; x++)
            check_field($sformatf("pixel_%0d", x), e.px[x], got_px[x]);
          check_field("last_row", e.last, out_last_row);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  cfg_w = cfg_data[3:0];
          CFG_HEIGHT: cfg_h = cfg_data[5:0];
          CFG_COUNT:  cfg_n = cfg_data;
          CFG_TABLE:  cfg_tbl = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_word();
    end
    rows_due <= expected_rows.size();
  end

endmodule

// ===== tb/bitmap_font_map_and_raster_tb.sv =====
`timescale 1ns / 100ps

module bitmap_font_map_and_raster_tb;
  import bfmr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_glyph_index;
  logic [4:0]  in_row_number;
  logic [20:0] in_codepoint;
  logic [31:0] in_fg_color;
  logic [31:0] in_bg_color;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [4:0]  out_out_row;
  logic [31:0] out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3;
  logic [31:0] out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7;
  logic        out_last_row;
  int          mismatches;
  int          rows_due;
  int          words_seen;

  int          snd_idle;
  int          rcv_idle;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  int          cycles;
  int          words_sent;
  int          renders_sent;
  logic [31:0] rows_ok [512];
  logic [3:0]  cur_w;
  logic [5:0]  cur_h;
  logic [9:0]  cur_n;
  logic        cur_tbl;
  logic        map_dirty;
  logic [20:0] mapped_cps[$];

  bitmap_font_map_and_raster i_dut (.*);

  font_raster_checker i_chk (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic send(input logic [1:0] a, input logic [7:0] d, input logic [8:0] gi,
                      input logic [4:0] rw, input logic [20:0] cp,
                      input logic [31:0] fg, input logic [31:0] bg);
    in_valid <= 1'b1;
    in_action <= a;
    in_data_byte <= d;
    in_glyph_index <= gi;
    in_row_number <= rw;
    in_codepoint <= cp;
    in_fg_color <= fg;
    in_bg_color <= bg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (a == ACT_RENDER) renders_sent++;
    if (a == ACT_WRITE) rows_ok[gi][rw] = 1'b1;
    if (a == ACT_TABLE) map_dirty = 1'b1;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(ACT_TABLE, b, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_row(input logic [8:0] g, input logic [4:0] rw);
    send(ACT_WRITE, $urandom, g, rw, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    map_dirty = 1'b0;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:  cur_w = val[3:0];
      CFG_HEIGHT: cur_h = val[5:0];
      CFG_COUNT:  cur_n = val;
      default:    cur_tbl = val[0];
    endcase
  endtask

  // True when rendering cp reads only rows that have been written.
  function automatic logic renderable(input logic [20:0] cp);
    int h, lim;
    logic [20:0] g;
    h = (cur_h == 0) ? 1 : (cur_h > 32) ? 32 : cur_h;
    lim = (cur_n > 512) ? 512 : cur_n;
    if (cur_tbl && cp >= 21'd65536) return 1'b1;
    g = cur_tbl ? {12'd0, i_chk.glyph_of(cp)} : cp;
    if (g >= lim) return 1'b1;
    for (int y = 0; y < h; y++)
      if (!rows_ok[g[8:0]][y]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic try_render();
    logic [20:0] cp;
    int k;
    if (cur_tbl && map_dirty) drain();
    for (int t = 0; t < 8; t++) begin
      k = $urandom_range(99);
      if (cur_tbl && mapped_cps.size() > 0 && k < 70)
        cp = mapped_cps[$urandom_range(mapped_cps.size() - 1)];
      else if (k < 85)
        cp = $urandom_range(7);
      else if (k < 93)
        cp = $urandom_range(511);
      else
        cp = $urandom;
      if (renderable(cp)) begin
        send(ACT_RENDER, $urandom, $urandom, $urandom, cp, $urandom, $urandom);
        return;
      end
    end
    write_row($urandom_range(7), $urandom);
  endtask

  // A UTF-8 sequence with random content, or a separator, or a malformed one.
  task automatic table_seq();
    logic [20:0] cp;
    int k;
    k = $urandom_range(99);
    cp = $urandom;
    if (k < 5) begin
      send_byte(BYTE_GLYPH_SEP);
    end else if (k < 25) begin
      cp = $urandom_range(127);
      send_byte(cp[7:0]);
    end else if (k < 45) begin
      cp = $urandom_range(2047);
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (k < 70) begin
      cp = ($urandom_range(9) == 0) ? 21'hFFFF : {5'd0, cp[15:0]};
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (k < 80) begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (k < 90) begin
      send_byte($urandom);
      cp = 21'h1FFFFF;
    end else begin
      send_byte({4'b1110, cp[3:0]});
      send_byte($urandom);
      send_byte($urandom);
      cp = 21'h1FFFFF;
    end
    if (cp < 21'd65535 && k >= 5) begin
      mapped_cps.push_back(cp);
      if (mapped_cps.size() > 24) void'(mapped_cps.pop_front());
    end
  endtask

  task automatic random_word();
    int k;
    k = $urandom_range(99);
    if (k < 30) table_seq();
    else if (k < 55) write_row(($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                               $urandom);
    else if (k < 95) try_render();
    else send(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [7:0] seq_bytes[] = '{8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                                8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h9F, 8'h98, 8'h80,
                                8'h80, 8'hF8, 8'hFE, 8'hC3, 8'h41, 8'hC3, 8'hFF,
                                8'hC0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    int widths[7]  = '{8, 15, 1, 0, 5, 8, 3};
    int heights[7] = '{16, 0, 1, 63, 32, 8, 7};
    int counts[7]  = '{256, 1023, 1, 0, 512, 4, 200};
    int tables[7]  = '{0, 1, 1, 0, 1, 0, 1};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_NONE;
    in_data_byte = '0;
    in_glyph_index = '0;
    in_row_number = '0;
    in_codepoint = '0;
    in_fg_color = '0;
    in_bg_color = '0;
    out_stall = 1'b0;
    snd_idle = 26;
    rcv_idle = 86;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    cycles = 0;
    words_sent = 0;
    renders_sent = 0;
    map_dirty = 1'b0;
    cur_w = 4'd8;
    cur_h = 6'd16;
    cur_n = 10'd256;
    cur_tbl = 1'b0;
    for (int g = 0; g < 512; g++) rows_ok[g] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill a few glyphs completely so renders have data at any height.
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < 32; r++) write_row(g, r);

    send(ACT_NONE, 8'hFF, 9'h1FF, 5'h1F, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(ACT_WRITE, 8'h00, 9'd1, 5'd31, 21'd0, 32'd0, 32'd0);
    send(ACT_WRITE, 8'hFF, 9'd1, 5'd0, 21'd0, 32'd0, 32'd0);
    send(ACT_RENDER, 8'd0, 9'd0, 5'd0, 21'd0, 32'hFFFFFFFF, 32'h0);
    send(ACT_RENDER, 8'd0, 9'd0, 5'd0, 21'd1, 32'h0, 32'hFFFFFFFF);
    send(ACT_RENDER, 8'd0, 9'd0, 5'd0, 21'h1FFFFF, 32'h0, 32'h0);
    foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
    mapped_cps.push_back(21'h41);
    mapped_cps.push_back(21'hE9);
    mapped_cps.push_back(21'h20AC);
    mapped_cps.push_back(21'h0);

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        snd_idle = 86;
        rcv_idle = 26;
      end else if (p == 5) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      drain();
      set_reg(CFG_WIDTH, widths[p]);
      set_reg(CFG_HEIGHT, heights[p]);
      set_reg(CFG_COUNT, counts[p]);
      set_reg(CFG_TABLE, tables[p]);
      // The result side holds off while words keep coming, so the block backs up.
      if (p == 4) hold_req = hold_req + 1;
      for (int i = 0; i < 28; i++) random_word();
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d words (%0d renders) over 7 register settings; checked %0d results.",
             words_sent, renders_sent, words_seen);
    if (mismatches == 0 && rows_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bfmr_pkg.sv
design/bfmr_front.sv
design/bfmr_queue.sv
design/bfmr_back.sv
design/bitmap_font_map_and_raster.sv
design/bfmr_checker.sv
tb/font_raster_checker.sv
tb/bitmap_font_map_and_raster_tb.sv
